[hdl/ajb_pkg.sv]
// ----------------------------------------------------------------------------
// ajb_pkg
// Types and codes shared by the jitter buffer and its entry ring.
// ----------------------------------------------------------------------------
`default_nettype none

package ajb_pkg;

    typedef struct packed {
        logic [15:0] handle;
        logic [31:0] arrival;
        logic [31:0] tick;
    } entry_t;

    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_FLUSH = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;

    localparam logic [2:0] KIND_STORED   = 3'd0;
    localparam logic [2:0] KIND_REPLACED = 3'd1;
    localparam logic [2:0] KIND_EVICTED  = 3'd2;
    localparam logic [2:0] KIND_LATE     = 3'd3;
    localparam logic [2:0] KIND_RELEASED = 3'd4;
    localparam logic [2:0] KIND_NONE     = 3'd5;
    localparam logic [2:0] KIND_RESET    = 3'd6;

    localparam logic [2:0] REG_INITIAL_DELAY   = 3'd0;
    localparam logic [2:0] REG_ADAPTIVE_ENABLE = 3'd1;
    localparam logic [2:0] REG_MAX_ENTRIES     = 3'd2;
    localparam logic [2:0] REG_SMOOTHING_GAIN  = 3'd3;
    localparam logic [2:0] REG_DELAY_SCALE     = 3'd4;
    localparam logic [2:0] REG_MIN_DELAY       = 3'd5;
    localparam logic [2:0] REG_MAX_DELAY       = 3'd6;

    localparam logic [23:0] RST_INITIAL_DELAY = 24'd50000;
    localparam logic [4:0]  RST_MAX_ENTRIES   = 5'd16;
    localparam logic [15:0] RST_GAIN          = 16'd6554;
    localparam logic [15:0] RST_SCALE         = 16'd1024;
    localparam logic [23:0] RST_MIN_DELAY     = 24'd10000;
    localparam logic [23:0] RST_MAX_DELAY     = 24'd500000;

    localparam logic [4:0] MAX_OUT = 5'd16;

endpackage

`default_nettype wire

[hdl/ajb_ring.sv]
// ----------------------------------------------------------------------------
// ajb_ring
// Circular entry store addressed by position from the front entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ajb_ring #(
    parameter int DEPTH = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 clr,
    input  wire logic                                 adv,
    input  wire logic                                 rd_en,
    input  wire logic [$clog2(DEPTH+1)-1:0]           rd_idx,
    input  wire logic                                 wr_en,
    input  wire logic [$clog2(DEPTH+1)-1:0]           wr_idx,
    input  wire ajb_pkg::entry_t                      wr_data,
    output ajb_pkg::entry_t                           rd_data
);
    import ajb_pkg::*;

    localparam int SZ = DEPTH + 1;
    localparam int AW = $clog2(SZ);

    entry_t          mem [SZ];
    logic [AW-1:0]   head_reg;
    entry_t          rd_data_reg;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] i);
        logic [AW:0] s;
        s = {1'b0, h} + {1'b0, i};
        if (s >= (AW+1)'(SZ))
        begin
            s = s - (AW+1)'(SZ);
        end
        return s[AW-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else if (clr)
        begin
            head_reg <= '0;
        end
        else if (adv)
        begin
            head_reg <= phys(head_reg, AW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[phys(head_reg, wr_idx)] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[phys(head_reg, rd_idx)];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/adaptive_jitter_buffer.sv]
// ----------------------------------------------------------------------------
// adaptive_jitter_buffer
// Tick-ordered jitter buffer with adaptive hold delay.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Contents
// cfg       in   cfg_we             cfg_index, cfg_data
// s_axis    in   tvalid/tready      tuser op; tdata tick,arrival,handle,now
// m_axis    out  tvalid/tready      tuser kind; tlast; tdata result fields
//
// Push: optional jitter and delay update, then a scan for the slot, a shift of
// later entries and evictions over the cap; a late push is dropped unscanned.
// Flush releases ready entries from the front; one shared 32x16 multiplier.
// Reset clears control state; store contents are left as they are.
// A result waits in the output register; the sequencer stalls only when
// it must load a result while the previous one is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_jitter_buffer #(
    parameter int DEPTH = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [23:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tick[31:0], arrival_time[63:32], payload_handle[79:64], current_time[111:80]
    input  wire logic [111:0] s_axis_tdata,
    // op[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_tick[31:0], out_arrival[63:32], out_handle[79:64], occupancy[84:80],
    // current_delay[108:85], pushed_count[140:109], dropped_count[172:141]
    output logic [175:0]      m_axis_tdata,
    // kind[2:0]
    output logic [2:0]        m_axis_tuser,
    output logic              m_axis_tlast
);
    import ajb_pkg::*;

    localparam int AW = $clog2(DEPTH + 1);
    localparam int CW = $clog2(DEPTH + 2);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DEC  = 5'd1;
    localparam logic [4:0] S_GAP  = 5'd2;
    localparam logic [4:0] S_SAMP = 5'd3;
    localparam logic [4:0] S_DIFF = 5'd4;
    localparam logic [4:0] S_MULJ = 5'd5;
    localparam logic [4:0] S_UPDJ = 5'd6;
    localparam logic [4:0] S_MULD = 5'd7;
    localparam logic [4:0] S_UPDD = 5'd8;
    localparam logic [4:0] S_SRD  = 5'd9;
    localparam logic [4:0] S_SCHK = 5'd10;
    localparam logic [4:0] S_HRD  = 5'd11;
    localparam logic [4:0] S_HWR  = 5'd12;
    localparam logic [4:0] S_EVCT = 5'd13;
    localparam logic [4:0] S_DONE = 5'd14;
    localparam logic [4:0] S_FRD  = 5'd15;
    localparam logic [4:0] S_FCHK = 5'd16;
    localparam logic [4:0] S_FEND = 5'd17;

    logic [4:0]    state_reg, state_next;
    logic [1:0]    op_reg;
    entry_t        in_ent_reg;
    logic [31:0]   now_reg;

    logic [23:0]   init_delay_reg, init_delay_next;
    logic          adapt_en_reg, adapt_en_next;
    logic [4:0]    max_entries_reg, max_entries_next;
    logic [15:0]   gain_reg, gain_next;
    logic [15:0]   scale_reg, scale_next;
    logic [23:0]   min_delay_reg, min_delay_next;
    logic [23:0]   max_delay_reg, max_delay_next;

    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   last_rel_reg, last_rel_next;
    logic [31:0]   smooth_reg, smooth_next;
    logic [31:0]   prev_arr_reg, prev_arr_next;
    logic [31:0]   prev_gap_reg, prev_gap_next;
    logic          first_reg, first_next;
    logic [23:0]   hold_reg, hold_next;
    logic [31:0]   push_tot_reg, push_tot_next;
    logic [31:0]   drop_tot_reg, drop_tot_next;
    logic [31:0]   work_reg, work_next;
    logic          up_reg, up_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] j_reg, j_next;
    logic [2:0]    kind_reg, kind_next;
    logic [4:0]    fl_n_reg, fl_n_next;
    entry_t        pend_reg, pend_next;
    logic          have_pend_reg, have_pend_next;

    logic [31:0]   mul_a;
    logic [15:0]   mul_b;
    logic [47:0]   prod_reg;

    logic          rg_clr, rg_adv, rg_rd_en, rg_wr_en;
    logic [AW-1:0] rg_rd_idx, rg_wr_idx;
    entry_t        rg_wr_data, rg_rd_data;

    logic          out_free, out_load, out_last;
    logic [2:0]    out_kind;
    entry_t        out_ent;
    logic          m_valid_reg;
    logic [175:0]  m_data_reg;
    logic [2:0]    m_user_reg;
    logic          m_last_reg;

    logic [CW-1:0] cap;

    ajb_ring #(.DEPTH(DEPTH)) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr     (rg_clr),
        .adv     (rg_adv),
        .rd_en   (rg_rd_en),
        .rd_idx  (rg_rd_idx),
        .wr_en   (rg_wr_en),
        .wr_idx  (rg_wr_idx),
        .wr_data (rg_wr_data),
        .rd_data (rg_rd_data)
    );

    always_comb
    begin
        if (max_entries_reg == 5'd0)
        begin
            cap = CW'(1);
        end
        else if (32'(max_entries_reg) > DEPTH)
        begin
            cap = CW'(DEPTH);
        end
        else
        begin
            cap = CW'(max_entries_reg);
        end
    end

    assign mul_a = (state_reg == S_MULD) ? smooth_reg : work_reg;
    assign mul_b = (state_reg == S_MULD) ? scale_reg : gain_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign out_free      = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb
    begin
        logic [48:0] rsum;
        logic [40:0] adp;
        logic [31:0] elapsed;
        logic        ready_e;

        state_next       = state_reg;
        init_delay_next  = init_delay_reg;
        adapt_en_next    = adapt_en_reg;
        max_entries_next = max_entries_reg;
        gain_next        = gain_reg;
        scale_next       = scale_reg;
        min_delay_next   = min_delay_reg;
        max_delay_next   = max_delay_reg;
        count_next       = count_reg;
        last_rel_next    = last_rel_reg;
        smooth_next      = smooth_reg;
        prev_arr_next    = prev_arr_reg;
        prev_gap_next    = prev_gap_reg;
        first_next       = first_reg;
        hold_next        = hold_reg;
        push_tot_next    = push_tot_reg;
        drop_tot_next    = drop_tot_reg;
        work_next        = work_reg;
        up_next          = up_reg;
        idx_next         = idx_reg;
        j_next           = j_reg;
        kind_next        = kind_reg;
        fl_n_next        = fl_n_reg;
        pend_next        = pend_reg;
        have_pend_next   = have_pend_reg;
        rg_clr           = 1'b0;
        rg_adv           = 1'b0;
        rg_rd_en         = 1'b0;
        rg_rd_idx        = '0;
        rg_wr_en         = 1'b0;
        rg_wr_idx        = '0;
        rg_wr_data       = in_ent_reg;
        out_load         = 1'b0;
        out_kind         = kind_reg;
        out_ent          = '0;
        out_last         = 1'b1;
        rsum             = '0;
        adp              = '0;
        elapsed          = now_reg - rg_rd_data.arrival;
        ready_e          = (now_reg >= rg_rd_data.arrival) && (elapsed >= {8'd0, hold_reg});

        if (cfg_we)
        begin
            case (cfg_index)
                REG_INITIAL_DELAY:
                begin
                    init_delay_next = cfg_data;
                    hold_next = (cfg_data > min_delay_reg) ? cfg_data : min_delay_reg;
                end
                REG_ADAPTIVE_ENABLE: adapt_en_next = cfg_data[0];
                REG_MAX_ENTRIES:     max_entries_next = cfg_data[4:0];
                REG_SMOOTHING_GAIN:  gain_next = cfg_data[15:0];
                REG_DELAY_SCALE:     scale_next = cfg_data[15:0];
                REG_MIN_DELAY:       min_delay_next = cfg_data;
                REG_MAX_DELAY:       max_delay_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                idx_next = '0;
                case (op_reg)
                    OP_PUSH:
                    begin
                        push_tot_next = push_tot_reg + 32'd1;
                        if (in_ent_reg.tick <= last_rel_reg && last_rel_reg != 32'd0)
                        begin
                            drop_tot_next = drop_tot_reg + 32'd1;
                            kind_next = KIND_LATE;
                            state_next = S_DONE;
                        end
                        else if (adapt_en_reg && first_reg)
                        begin
                            first_next = 1'b0;
                            prev_arr_next = in_ent_reg.arrival;
                            state_next = S_SRD;
                        end
                        else if (adapt_en_reg)
                        begin
                            state_next = S_GAP;
                        end
                        else
                        begin
                            state_next = S_SRD;
                        end
                    end
                    OP_FLUSH:
                    begin
                        fl_n_next = '0;
                        have_pend_next = 1'b0;
                        state_next = S_FRD;
                    end
                    OP_RESET:
                    begin
                        rg_clr = 1'b1;
                        count_next = '0;
                        last_rel_next = '0;
                        smooth_next = '0;
                        prev_arr_next = '0;
                        prev_gap_next = '0;
                        first_next = 1'b1;
                        push_tot_next = '0;
                        drop_tot_next = '0;
                        kind_next = KIND_RESET;
                        state_next = S_DONE;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_GAP:
            begin
                prev_arr_next = in_ent_reg.arrival;
                work_next = in_ent_reg.arrival - prev_arr_reg;
                state_next = (in_ent_reg.arrival >= prev_arr_reg) ? S_SAMP : S_SRD;
            end
            S_SAMP:
            begin
                prev_gap_next = work_reg;
                work_next = (work_reg >= prev_gap_reg) ? work_reg - prev_gap_reg
                                                       : prev_gap_reg - work_reg;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                up_next = (work_reg >= smooth_reg);
                work_next = (work_reg >= smooth_reg) ? work_reg - smooth_reg
                                                     : smooth_reg - work_reg;
                state_next = S_MULJ;
            end
            S_MULJ: state_next = S_UPDJ;
            S_UPDJ:
            begin
                rsum = {1'b0, prod_reg} + 49'd32768;
                smooth_next = up_reg ? smooth_reg + rsum[47:16] : smooth_reg - rsum[47:16];
                state_next = S_MULD;
            end
            S_MULD: state_next = S_UPDD;
            S_UPDD:
            begin
                rsum = {1'b0, prod_reg} + 49'd128;
                adp = rsum[48:8];
                if (adp > 41'(max_delay_reg))
                begin
                    adp = 41'(max_delay_reg);
                end
                if (adp < 41'(min_delay_reg))
                begin
                    adp = 41'(min_delay_reg);
                end
                hold_next = adp[23:0];
                state_next = S_SRD;
            end
            S_SRD:
            begin
                if (idx_reg < count_reg)
                begin
                    rg_rd_en = 1'b1;
                    rg_rd_idx = idx_reg[AW-1:0];
                    state_next = S_SCHK;
                end
                else
                begin
                    j_next = count_reg;
                    state_next = S_HRD;
                end
            end
            S_SCHK:
            begin
                if (rg_rd_data.tick < in_ent_reg.tick)
                begin
                    idx_next = idx_reg + CW'(1);
                    state_next = S_SRD;
                end
                else if (rg_rd_data.tick == in_ent_reg.tick)
                begin
                    rg_wr_en = 1'b1;
                    rg_wr_idx = idx_reg[AW-1:0];
                    kind_next = KIND_REPLACED;
                    state_next = S_EVCT;
                end
                else
                begin
                    j_next = count_reg;
                    state_next = S_HRD;
                end
            end
            S_HRD:
            begin
                if (j_reg > idx_reg)
                begin
                    rg_rd_en = 1'b1;
                    rg_rd_idx = AW'(j_reg - CW'(1));
                    state_next = S_HWR;
                end
                else
                begin
                    rg_wr_en = 1'b1;
                    rg_wr_idx = idx_reg[AW-1:0];
                    count_next = count_reg + CW'(1);
                    kind_next = KIND_STORED;
                    state_next = S_EVCT;
                end
            end
            S_HWR:
            begin
                rg_wr_en = 1'b1;
                rg_wr_idx = j_reg[AW-1:0];
                rg_wr_data = rg_rd_data;
                j_next = j_reg - CW'(1);
                state_next = S_HRD;
            end
            S_EVCT:
            begin
                if (count_reg > cap)
                begin
                    rg_adv = 1'b1;
                    count_next = count_reg - CW'(1);
                    drop_tot_next = drop_tot_reg + 32'd1;
                    kind_next = KIND_EVICTED;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_FRD:
            begin
                if (fl_n_reg < MAX_OUT && count_reg != '0)
                begin
                    rg_rd_en = 1'b1;
                    rg_rd_idx = '0;
                    state_next = S_FCHK;
                end
                else
                begin
                    state_next = S_FEND;
                end
            end
            S_FCHK:
            begin
                if (!ready_e)
                begin
                    state_next = S_FEND;
                end
                else if (!have_pend_reg || out_free)
                begin
                    if (have_pend_reg)
                    begin
                        out_load = 1'b1;
                        out_kind = KIND_RELEASED;
                        out_ent = pend_reg;
                        out_last = 1'b0;
                    end
                    pend_next = rg_rd_data;
                    have_pend_next = 1'b1;
                    last_rel_next = rg_rd_data.tick;
                    rg_adv = 1'b1;
                    count_next = count_reg - CW'(1);
                    fl_n_next = fl_n_reg + 5'd1;
                    state_next = S_FRD;
                end
            end
            S_FEND:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    out_kind = have_pend_reg ? KIND_RELEASED : KIND_NONE;
                    out_ent = have_pend_reg ? pend_reg : '0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg             <= s_axis_tuser;
            in_ent_reg.tick    <= s_axis_tdata[31:0];
            in_ent_reg.arrival <= s_axis_tdata[63:32];
            in_ent_reg.handle  <= s_axis_tdata[79:64];
            now_reg            <= s_axis_tdata[111:80];
        end
        work_reg <= work_next;
        up_reg   <= up_next;
        j_reg    <= j_next;
        pend_reg <= pend_next;
        if (out_load)
        begin
            m_data_reg <= {3'd0, drop_tot_next, push_tot_next, hold_next,
                           5'(count_reg), out_ent.handle, out_ent.arrival, out_ent.tick};
            m_user_reg <= out_kind;
            m_last_reg <= out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            init_delay_reg  <= RST_INITIAL_DELAY;
            adapt_en_reg    <= 1'b1;
            max_entries_reg <= RST_MAX_ENTRIES;
            gain_reg        <= RST_GAIN;
            scale_reg       <= RST_SCALE;
            min_delay_reg   <= RST_MIN_DELAY;
            max_delay_reg   <= RST_MAX_DELAY;
            count_reg       <= '0;
            last_rel_reg    <= '0;
            smooth_reg      <= '0;
            prev_arr_reg    <= '0;
            prev_gap_reg    <= '0;
            first_reg       <= 1'b1;
            hold_reg        <= RST_INITIAL_DELAY;
            push_tot_reg    <= '0;
            drop_tot_reg    <= '0;
            idx_reg         <= '0;
            kind_reg        <= KIND_STORED;
            fl_n_reg        <= '0;
            have_pend_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            init_delay_reg  <= init_delay_next;
            adapt_en_reg    <= adapt_en_next;
            max_entries_reg <= max_entries_next;
            gain_reg        <= gain_next;
            scale_reg       <= scale_next;
            min_delay_reg   <= min_delay_next;
            max_delay_reg   <= max_delay_next;
            count_reg       <= count_next;
            last_rel_reg    <= last_rel_next;
            smooth_reg      <= smooth_next;
            prev_arr_reg    <= prev_arr_next;
            prev_gap_reg    <= prev_gap_next;
            first_reg       <= first_next;
            hold_reg        <= hold_next;
            push_tot_reg    <= push_tot_next;
            drop_tot_reg    <= drop_tot_next;
            idx_reg         <= idx_next;
            kind_reg        <= kind_next;
            fl_n_reg        <= fl_n_next;
            have_pend_reg   <= have_pend_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> count_reg <= CW'(DEPTH))
        else $error("entry count above depth while idle");

    a_flush_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fl_n_reg <= MAX_OUT)
        else $error("flush released too many entries");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_axis_tready) |-> !out_load)
        else $error("held result overwritten");

    a_last_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && (state_next == S_IDLE) |-> out_last)
        else $error("final result without last");

endmodule

`default_nettype wire
